// ----- sv/assert_macros.svh -----
// Assertion macros shared by the scheduler RTL.
// Both macros take a label, a clock, an active-low reset and the checked expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed: expression does not hold");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: consequent missing one cycle later");

`endif

// ----- sv/mlfs_pkg.sv -----
// Package for the multilevel feedback scheduler: codes, constants and shared types.
// Depends on nothing; every other RTL file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package mlfs_pkg;

	// Width and ceiling of the time slice counter.
	localparam int QUANT_W = 18;
	localparam logic [QUANT_W-1:0] QUANT_MAX = 18'h3FFFF;

	// Fixed widths of configuration registers and result fields.
	localparam int QBASE_W     = 16;
	localparam int NLEVELS_W   = 3;
	localparam int LEVEL_OUT_W = 2;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [QBASE_W-1:0]   QBASE_RESET   = 16'd1;
	localparam logic [NLEVELS_W-1:0] NLEVELS_RESET = 3'd4;

	typedef enum logic {
		REQ_ARRIVAL = 1'b0,
		REQ_TICK    = 1'b1
	} req_t;

	typedef enum logic [2:0] {
		OUT_NONE     = 3'd0,
		OUT_FINISHED = 3'd1,
		OUT_DEMOTED  = 3'd2,
		OUT_QUEUED   = 3'd3,
		OUT_STARTED  = 3'd4,
		OUT_DROPPED  = 3'd5
	} outcome_t;

	typedef enum logic [0:0] {
		REG_QUANTUM_BASE = 1'b0,
		REG_NUM_LEVELS   = 1'b1
	} reg_idx_t;

	// Configuration as seen by the scheduling logic.
	typedef struct packed {
		logic [QBASE_W-1:0]   quantum_base;
		logic [NLEVELS_W-1:0] num_levels;
	} cfg_t;

	// Status of one level FIFO.
	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage

`default_nettype wire

// ----- sv/multilevel_feedback_scheduler.sv -----
// Multilevel feedback scheduler, top level.
// An accepted item passes through the input register and the result register before done strobes its result.
// Throughput: one item per clock cycle; busy stays low and the receiver cannot stall.
// Reset (arst_n, asynchronous, active low) empties every level FIFO, idles the processor
// and loads quantum_base = 1 and num_levels = 4; the FIFO memories themselves are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module multilevel_feedback_scheduler #(
	parameter int MAX_LEVELS  = 4,
	parameter int FIFO_DEPTH  = 16,
	parameter int ID_BITS     = 8,
	parameter int LENGTH_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// Item input
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic                                  req_type,
	input  wire logic [ID_BITS-1:0]                    task_id,
	input  wire logic [LENGTH_BITS-1:0]                task_length,
	// Result output
	output logic                                       done,
	output logic                                       running_valid,
	output logic      [ID_BITS-1:0]                    running_id,
	output logic      [2:0]                            outcome,
	output logic      [mlfs_pkg::LEVEL_OUT_W-1:0]      running_level,
	// Configuration port
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [mlfs_pkg::APB_ADDR_W-1:0]       paddr,
	input  wire logic [mlfs_pkg::APB_DATA_W-1:0]       pwdata,
	output logic      [mlfs_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                       pready
);

	localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int ENT_W = ID_BITS + LENGTH_BITS;
	// Width of the (level + 1) * base product, and of the slice before saturation.
	localparam int PW    = LVL_W + 1 + mlfs_pkg::QBASE_W;
	localparam int WW    = ((LENGTH_BITS > PW) ? LENGTH_BITS : PW) + 1;

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	mlfs_pkg::cfg_t cfg;

	mlfs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ------------------------------------------------------------------
	// Input register. Every offered item is taken, so busy is tied low.
	// ------------------------------------------------------------------
	logic                   accept;
	logic                   valid_s1;
	mlfs_pkg::req_t         req_s1;
	logic [ID_BITS-1:0]     id_s1;
	logic [LENGTH_BITS-1:0] len_s1;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= mlfs_pkg::req_t'(req_type);
			id_s1  <= task_id;
			len_s1 <= task_length;
		end
	end

	// ------------------------------------------------------------------
	// Level FIFOs. At most one push and one pop reach them per item.
	// ------------------------------------------------------------------
	logic                 push_en;
	logic [LVL_W-1:0]     push_lvl;
	logic [ENT_W-1:0]     push_data;
	logic                 pop_en;
	logic [LVL_W-1:0]     sel_lvl;
	logic [ENT_W-1:0]     head_data [MAX_LEVELS];
	mlfs_pkg::fifo_stat_t stat      [MAX_LEVELS];

	for (genvar l = 0; l < MAX_LEVELS; l++) begin : g_level
		mlfs_fifo #(
			.DEPTH (FIFO_DEPTH),
			.W     (ENT_W)
		) u_fifo (
			.clk       (clk),
			.arst_n    (arst_n),
			.push      (push_en && (push_lvl == LVL_W'(l))),
			.push_data (push_data),
			.pop       (pop_en && (sel_lvl == LVL_W'(l))),
			.head_data (head_data[l]),
			.stat      (stat[l])
		);
	end

	// ------------------------------------------------------------------
	// Processor state.
	// ------------------------------------------------------------------
	logic                         proc_busy_q;
	logic [ID_BITS-1:0]           cur_id_q;
	logic [LENGTH_BITS-1:0]       rem_q;
	logic [mlfs_pkg::QUANT_W-1:0] quant_q;
	logic [LVL_W-1:0]             level_q;

	// Out-of-range register values are folded here: a zero base acts as one,
	// and the number of levels is clamped to the range one to MAX_LEVELS.
	logic [mlfs_pkg::QBASE_W-1:0] base_slice;
	logic [LVL_W-1:0]             last_lvl;

	assign base_slice = (cfg.quantum_base == '0) ? mlfs_pkg::QBASE_W'(1) : cfg.quantum_base;

	always_comb begin
		if (cfg.num_levels == '0) begin
			last_lvl = '0;
		end else if ({1'b0, cfg.num_levels} > (mlfs_pkg::NLEVELS_W + 1)'(MAX_LEVELS)) begin
			last_lvl = LVL_W'(MAX_LEVELS - 1);
		end else begin
			last_lvl = LVL_W'(cfg.num_levels - mlfs_pkg::NLEVELS_W'(1));
		end
	end

	// Lowest non-empty level and the task waiting at its head. Every level
	// that exists in hardware is scanned, whatever num_levels says.
	logic                         any_waiting;
	logic [ENT_W-1:0]             pop_entry;
	logic [ID_BITS-1:0]           pop_id;
	logic [LENGTH_BITS-1:0]       pop_len;
	logic [PW-1:0]                prod;
	logic [WW-1:0]                slice_wide;
	logic [mlfs_pkg::QUANT_W-1:0] pop_quant;

	always_comb begin
		any_waiting = 1'b0;
		sel_lvl     = '0;
		for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
			if (!stat[l].empty) begin
				any_waiting = 1'b1;
				sel_lvl     = LVL_W'(l);
			end
		end
	end

	// A task on a level below the last gets (level + 1) base slices; on the
	// last level or above it its slice is its whole remaining work. Either way the slice
	// saturates at the largest value the counter holds.
	always_comb begin
		pop_entry  = head_data[sel_lvl];
		pop_id     = pop_entry[ENT_W-1:LENGTH_BITS];
		pop_len    = (pop_entry[LENGTH_BITS-1:0] == '0) ? LENGTH_BITS'(1)
		                                                : pop_entry[LENGTH_BITS-1:0];
		prod       = (PW'(sel_lvl) + PW'(1)) * PW'(base_slice);
		slice_wide = (sel_lvl < last_lvl) ? WW'(prod) : WW'(pop_len);
		pop_quant  = (slice_wide > WW'(mlfs_pkg::QUANT_MAX)) ? mlfs_pkg::QUANT_MAX
		                                                    : slice_wide[mlfs_pkg::QUANT_W-1:0];
	end

	// ------------------------------------------------------------------
	// Scheduling decision for the item in the input register.
	// ------------------------------------------------------------------
	logic                         busy_n;
	logic [ID_BITS-1:0]           id_n;
	logic [LENGTH_BITS-1:0]       rem_n;
	logic [mlfs_pkg::QUANT_W-1:0] quant_n;
	logic [LVL_W-1:0]             level_n;
	logic                         res_valid;
	logic [ID_BITS-1:0]           res_id;
	mlfs_pkg::outcome_t           res_outcome;
	logic [LVL_W-1:0]             res_level;

	logic [LENGTH_BITS-1:0]       in_len;
	logic [ID_BITS-1:0]           c_id;
	logic [LENGTH_BITS-1:0]       c_rem;
	logic [mlfs_pkg::QUANT_W-1:0] c_quant;
	logic [LVL_W-1:0]             c_lvl;
	logic [LENGTH_BITS-1:0]       rem_dec;
	logic [mlfs_pkg::QUANT_W-1:0] quant_dec;
	logic [LVL_W-1:0]             target;
	logic                         target_full;

	assign in_len = (len_s1 == '0) ? LENGTH_BITS'(1) : len_s1;

	// The task the tick applies to: the one running, or else the one just
	// taken from the lowest non-empty level.
	assign c_id      = proc_busy_q ? cur_id_q : pop_id;
	assign c_rem     = proc_busy_q ? rem_q    : pop_len;
	assign c_quant   = proc_busy_q ? quant_q  : pop_quant;
	assign c_lvl     = proc_busy_q ? level_q  : sel_lvl;
	assign rem_dec   = c_rem - LENGTH_BITS'(1);
	assign quant_dec = (c_quant != '0) ? c_quant - mlfs_pkg::QUANT_W'(1) : '0;

	// Demotion goes one level down but never past the last level, and never up.
	assign target      = (c_lvl < last_lvl) ? c_lvl + LVL_W'(1) : c_lvl;
	// A pop from the same level in this item frees a slot before the push.
	assign target_full = stat[target].full && !(pop_en && (sel_lvl == target));

	always_comb begin
		busy_n      = proc_busy_q;
		id_n        = cur_id_q;
		rem_n       = rem_q;
		quant_n     = quant_q;
		level_n     = level_q;
		push_en     = 1'b0;
		push_lvl    = '0;
		push_data   = {id_s1, in_len};
		pop_en      = 1'b0;
		res_valid   = 1'b0;
		res_id      = '0;
		res_outcome = mlfs_pkg::OUT_NONE;
		res_level   = '0;

		if (valid_s1) begin
			case (req_s1)
				mlfs_pkg::REQ_ARRIVAL: begin
					res_valid = 1'b1;
					if (!proc_busy_q) begin
						// An idle processor takes the new task straight away at level 0.
						busy_n      = 1'b1;
						id_n        = id_s1;
						rem_n       = in_len;
						quant_n     = mlfs_pkg::QUANT_W'(base_slice);
						level_n     = '0;
						res_id      = id_s1;
						res_outcome = mlfs_pkg::OUT_STARTED;
					end else begin
						res_id    = cur_id_q;
						res_level = level_q;
						if (stat[0].full) begin
							res_outcome = mlfs_pkg::OUT_DROPPED;
						end else begin
							push_en     = 1'b1;
							res_outcome = mlfs_pkg::OUT_QUEUED;
						end
					end
				end
				mlfs_pkg::REQ_TICK: begin
					if (proc_busy_q || any_waiting) begin
						pop_en    = !proc_busy_q;
						res_valid = 1'b1;
						res_id    = c_id;
						res_level = c_lvl;
						id_n      = c_id;
						level_n   = c_lvl;
						rem_n     = rem_dec;
						quant_n   = quant_dec;
						if (rem_dec == '0) begin
							busy_n      = 1'b0;
							res_outcome = mlfs_pkg::OUT_FINISHED;
						end else if (quant_dec == '0) begin
							// Slice used up with work left: requeue one level down, or on the last level again.
							busy_n    = 1'b0;
							push_lvl  = target;
							push_data = {c_id, rem_dec};
							if (target_full) begin
								res_outcome = mlfs_pkg::OUT_DROPPED;
							end else begin
								push_en     = 1'b1;
								res_outcome = mlfs_pkg::OUT_DEMOTED;
							end
						end else begin
							busy_n      = 1'b1;
							res_outcome = mlfs_pkg::OUT_NONE;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_busy_q <= 1'b0;
			cur_id_q    <= '0;
			rem_q       <= '0;
			quant_q     <= '0;
			level_q     <= '0;
		end else begin
			proc_busy_q <= busy_n;
			cur_id_q    <= id_n;
			rem_q       <= rem_n;
			quant_q     <= quant_n;
			level_q     <= level_n;
		end
	end

	// ------------------------------------------------------------------
	// Result register: each item's result is shown for exactly one cycle.
	// ------------------------------------------------------------------
	logic                                done_q;
	logic                                running_valid_q;
	logic [ID_BITS-1:0]                  running_id_q;
	mlfs_pkg::outcome_t                  outcome_q;
	logic [mlfs_pkg::LEVEL_OUT_W-1:0]    running_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			running_valid_q <= res_valid;
			running_id_q    <= res_id;
			outcome_q       <= res_outcome;
			running_level_q <= mlfs_pkg::LEVEL_OUT_W'(res_level);
		end
	end

	assign done          = done_q;
	assign running_valid = running_valid_q;
	assign running_id    = running_id_q;
	assign outcome       = outcome_q;
	assign running_level = running_level_q;

	`ASSERT_NEXT(a_result_per_item, clk, arst_n, valid_s1, done_q)
	`ASSERT_ALWAYS(a_running_has_work, clk, arst_n, !proc_busy_q || (rem_q != '0))
	`ASSERT_ALWAYS(a_finish_frees_cpu, clk, arst_n, !(done_q && (outcome_q == mlfs_pkg::OUT_FINISHED)) || !proc_busy_q)

endmodule

`default_nettype wire

// ----- sv/mlfs_regs.sv -----
// Configuration registers of the scheduler behind an APB-style slave port.
// Depends on mlfs_pkg for register indexes, reset values and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module mlfs_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [mlfs_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [mlfs_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [mlfs_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                     pready,
	output mlfs_pkg::cfg_t                           cfg
);

	logic [mlfs_pkg::QBASE_W-1:0]   quantum_base_q;
	logic [mlfs_pkg::NLEVELS_W-1:0] num_levels_q;
	logic                           wr_en;
	mlfs_pkg::reg_idx_t             reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = mlfs_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_base_q <= mlfs_pkg::QBASE_RESET;
			num_levels_q   <= mlfs_pkg::NLEVELS_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				mlfs_pkg::REG_QUANTUM_BASE: quantum_base_q <= pwdata[mlfs_pkg::QBASE_W-1:0];
				mlfs_pkg::REG_NUM_LEVELS:   num_levels_q   <= pwdata[mlfs_pkg::NLEVELS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mlfs_pkg::REG_QUANTUM_BASE: prdata = mlfs_pkg::APB_DATA_W'(quantum_base_q);
			mlfs_pkg::REG_NUM_LEVELS:   prdata = mlfs_pkg::APB_DATA_W'(num_levels_q);
			default:                    prdata = '0;
		endcase
	end

	assign cfg.quantum_base = quantum_base_q;
	assign cfg.num_levels   = num_levels_q;

endmodule

`default_nettype wire

// ----- sv/mlfs_fifo.sv -----
// One priority level's FIFO: a memory with one write and one registered read port.
// The head entry is kept in the read register; depends on mlfs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mlfs_fifo #(
	parameter int DEPTH = 16,
	parameter int W     = 24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [W-1:0]  push_data,
	input  wire logic          pop,
	output logic      [W-1:0]  head_data,
	output mlfs_pkg::fifo_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem [DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] head_inc;
	logic [PTR_W-1:0] tail_inc;
	logic [PTR_W-1:0] rd_addr;
	logic [W-1:0]     head_data_q;

	assign head_inc = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	assign tail_inc = (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);

	// The read register always tracks the entry at the head pointer.
	assign rd_addr = pop ? head_inc : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_inc;
			end
			if (pop) begin
				head_q <= head_inc;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= push_data;
		end
	end

	// An entry written in this cycle to the slot that becomes the head is forwarded.
	always_ff @(posedge clk) begin
		if (push && (tail_q == rd_addr)) begin
			head_data_q <= push_data;
		end else begin
			head_data_q <= mem[rd_addr];
		end
	end

	assign head_data  = head_data_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(DEPTH));

	`ASSERT_ALWAYS(a_count_bounded, clk, arst_n, count_q <= CNT_W'(DEPTH))
	`ASSERT_ALWAYS(a_no_push_full, clk, arst_n, !(push && stat.full && !pop))

endmodule

`default_nettype wire
